### sv/tlbia_pkg.sv
// ----------------------------------------------------------------------------
// tlbia_pkg
// Shared types and constants of the two-level bitmap ID allocator.
// ----------------------------------------------------------------------------
package tlbia_pkg;

	localparam int CMD_W = 2;
	localparam int ID_W  = 14;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_QUERY = 2'd0;
	localparam cmd_t CMD_ALLOC = 2'd1;
	localparam cmd_t CMD_FREE  = 2'd2;
	localparam cmd_t CMD_NOP   = 2'd3;

endpackage

### sv/tlbia_ram.sv
// ----------------------------------------------------------------------------
// tlbia_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tlbia_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/two_level_bitmap_id_allocator_unit.sv
// A query divides its ID (ST_DIV1, ST_DIV2), then reads its bit (ST_QRES); a free
// divides twice, then clears the bit (ST_FWR); an allocate reads and checks the
// current leaf (ST_ARD, ST_ACHK). One that fills a leaf adds a directory scan, and
// one that finds its leaf already full adds a scan and a second leaf read. One item
// at a time: the sequencer and the single leaf memory port set the rate. After reset
// a clearing pass zeroes the leaf memory; no item is accepted during it.
// ----------------------------------------------------------------------------
// two_level_bitmap_id_allocator_unit
// ID allocator with one bit per ID in leaf words held in RAM and one bit per
// full leaf in directory words held in flops. Query, allocate and free items.
// ----------------------------------------------------------------------------
module two_level_bitmap_id_allocator_unit
	import tlbia_pkg::*;
#(
	parameter int WORD_BITS  = 64,
	parameter int NUM_DIRS   = 4,
	parameter int NUM_LEAVES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // cmd[1:0], id[15:2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // bit_value[0], alloc_id[14:1], full_res[15]
);

	localparam int BIT_W   = $clog2(WORD_BITS);
	localparam int LEAF_W  = $clog2(NUM_LEAVES);
	localparam int DIR_W   = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1;
	// Exact division of an ID_W-bit value by WORD_BITS via a reciprocal.
	localparam int DIV_SH  = ID_W + BIT_W;
	localparam int RECIP   = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int RECIP_W = ID_W + 2;
	localparam int PROD_W  = ID_W + RECIP_W;

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_DIV1  = 4'd2;
	localparam logic [3:0] ST_DIV2  = 4'd3;
	localparam logic [3:0] ST_QRES  = 4'd4;
	localparam logic [3:0] ST_FWR   = 4'd5;
	localparam logic [3:0] ST_ARD   = 4'd6;
	localparam logic [3:0] ST_ACHK  = 4'd7;
	localparam logic [3:0] ST_SCUR  = 4'd8;
	localparam logic [3:0] ST_SCAN  = 4'd9;
	localparam logic [3:0] ST_SLEAF = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

	function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] iso;
		logic [BIT_W-1:0]     idx;
		iso = ~w & (w + WORD_BITS'(1));
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (iso[i]) begin
				idx = idx | BIT_W'(i);
			end
		end
		return idx;
	endfunction

	logic [3:0]           state_q;
	cmd_t                 cmd_q;
	logic                 pass2_q;
	logic                 searched_q;
	logic                 pre_q;
	logic [LEAF_W-1:0]    clr_q;
	logic [ID_W-1:0]      x_q;
	logic [ID_W-1:0]      q_q;
	logic [BIT_W-1:0]     r_q;
	logic [LEAF_W-1:0]    leaf_q;
	logic [BIT_W-1:0]     fbit_q;
	logic [LEAF_W-1:0]    cur_leaf_q;
	logic [DIR_W-1:0]     cur_dir_q;
	logic [BIT_W-1:0]     cur_dbit_q;
	logic [ID_W-1:0]      base_q;
	logic [DIR_W-1:0]     scan_q;
	logic                 res_bit_q;
	logic [ID_W-1:0]      res_id_q;
	logic                 res_full_q;
	logic                 m_valid_q;
	logic [15:0]          m_data_q;
	logic [WORD_BITS-1:0] dir_q [NUM_DIRS];

	logic [WORD_BITS-1:0] dir_mask [NUM_DIRS];
	logic [PROD_W-1:0]    prod;
	logic [ID_W-1:0]      q_next;
	logic [BIT_W-1:0]     r_next;
	logic [DIR_W-1:0]     sidx;
	logic [WORD_BITS-1:0] srch_word;
	logic                 srch_full;
	logic [BIT_W-1:0]     srch_bit;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] alloc_word;
	logic [BIT_W-1:0]     alloc_bit;
	logic                 ram_we;
	logic [LEAF_W-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [LEAF_W-1:0]    ram_raddr;
	logic                 q_in_range;

	// Directory bits that name leaves beyond the last one count as full.
	for (genvar d = 0; d < NUM_DIRS; d++) begin : g_mask_d
		for (genvar b = 0; b < WORD_BITS; b++) begin : g_mask_b
			assign dir_mask[d][b] = ((d * WORD_BITS + b) < NUM_LEAVES) ? 1'b1 : 1'b0;
		end
	end

	assign prod   = PROD_W'(x_q) * PROD_W'(RECIP);
	assign q_next = ID_W'(prod >> DIV_SH);
	assign r_next = BIT_W'(x_q - ID_W'(q_q * ID_W'(WORD_BITS)));

	assign q_in_range = (int'(q_q) < NUM_LEAVES);

	assign sidx      = (state_q == ST_SCUR) ? cur_dir_q : scan_q;
	assign srch_word = dir_q[sidx] | ~dir_mask[sidx];
	assign srch_full = &srch_word;
	assign srch_bit  = lowest_clear(srch_word);

	assign alloc_bit  = lowest_clear(rdata);
	assign alloc_word = rdata | (WORD_BITS'(1) << alloc_bit);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_leaf_q;
		ram_wdata = alloc_word;
		ram_re    = 1'b0;
		ram_raddr = cur_leaf_q;
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_DIV2: begin
				ram_re    = q_in_range && !pass2_q;
				ram_raddr = LEAF_W'(q_q);
			end
			ST_FWR: begin
				ram_we    = 1'b1;
				ram_waddr = leaf_q;
				ram_wdata = rdata & ~(WORD_BITS'(1) << fbit_q);
			end
			ST_ARD: begin
				ram_re = 1'b1;
			end
			ST_ACHK: begin
				ram_we = (rdata != FULL_WORD);
			end
			default: begin
			end
		endcase
	end

	tlbia_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_LEAVES)
	) u_leaf_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			cmd_q      <= CMD_NOP;
			pass2_q    <= 1'b0;
			searched_q <= 1'b0;
			pre_q      <= 1'b0;
			clr_q      <= '0;
			x_q        <= '0;
			q_q        <= '0;
			r_q        <= '0;
			leaf_q     <= '0;
			fbit_q     <= '0;
			cur_leaf_q <= '0;
			cur_dir_q  <= '0;
			cur_dbit_q <= '0;
			base_q     <= '0;
			scan_q     <= '0;
			res_bit_q  <= 1'b0;
			res_id_q   <= '0;
			res_full_q <= 1'b0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
			for (int d = 0; d < NUM_DIRS; d++) begin
				dir_q[d] <= '0;
			end
		end else begin
			// In ST_OUT the output register is reloaded below instead.
			if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + LEAF_W'(1);
					if (clr_q == LEAF_W'(NUM_LEAVES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q      <= s_axis_tdata[CMD_W-1:0];
						x_q        <= s_axis_tdata[CMD_W +: ID_W];
						pass2_q    <= 1'b0;
						searched_q <= 1'b0;
						res_bit_q  <= 1'b0;
						res_id_q   <= '0;
						res_full_q <= 1'b0;
						unique case (s_axis_tdata[CMD_W-1:0])
							CMD_QUERY, CMD_FREE: state_q <= ST_DIV1;
							CMD_ALLOC:           state_q <= ST_ARD;
							default:             state_q <= ST_OUT;
						endcase
					end
				end
				ST_DIV1: begin
					q_q     <= q_next;
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					r_q <= r_next;
					if (cmd_q == CMD_QUERY) begin
						state_q <= q_in_range ? ST_QRES : ST_OUT;
					end else if (pass2_q) begin
						state_q <= ST_FWR;
					end else if (q_in_range) begin
						// Leaf word read is in flight; now split the leaf number.
						leaf_q  <= LEAF_W'(q_q);
						fbit_q  <= r_next;
						x_q     <= q_q;
						pass2_q <= 1'b1;
						state_q <= ST_DIV1;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_QRES: begin
					res_bit_q <= rdata[r_q];
					state_q   <= ST_OUT;
				end
				ST_FWR: begin
					if (int'(q_q) < NUM_DIRS) begin
						dir_q[DIR_W'(q_q)][r_q] <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_ARD: begin
					base_q  <= ID_W'(int'(cur_leaf_q) * WORD_BITS);
					state_q <= ST_ACHK;
				end
				ST_ACHK: begin
					if (rdata == FULL_WORD) begin
						if (searched_q) begin
							res_full_q <= 1'b1;
							state_q    <= ST_OUT;
						end else begin
							searched_q <= 1'b1;
							pre_q      <= 1'b1;
							state_q    <= ST_SCUR;
						end
					end else begin
						res_id_q <= base_q + ID_W'(alloc_bit);
						if (alloc_word == FULL_WORD) begin
							dir_q[cur_dir_q][cur_dbit_q] <= 1'b1;
							pre_q   <= 1'b0;
							state_q <= ST_SCUR;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SCUR: begin
					if (!srch_full) begin
						cur_dbit_q <= srch_bit;
						state_q    <= ST_SLEAF;
					end else begin
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!srch_full) begin
						cur_dir_q  <= scan_q;
						cur_dbit_q <= srch_bit;
						state_q    <= ST_SLEAF;
					end else if (scan_q == DIR_W'(NUM_DIRS - 1)) begin
						// No leaf left anywhere; a pending allocate reports full.
						if (pre_q) begin
							res_full_q <= 1'b1;
						end
						state_q <= ST_OUT;
					end else begin
						scan_q <= scan_q + DIR_W'(1);
					end
				end
				ST_SLEAF: begin
					cur_leaf_q <= LEAF_W'(int'(cur_dir_q) * WORD_BITS + int'(cur_dbit_q));
					state_q    <= pre_q ? ST_ARD : ST_OUT;
				end
				ST_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {res_full_q, res_id_q, res_bit_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

### sv/tlbia_chk.sv
// ----------------------------------------------------------------------------
// tlbia_chk
// Port-level checks of the ID allocator, bound to the top level.
// ----------------------------------------------------------------------------
module tlbia_chk
	import tlbia_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,  // cmd[1:0], id[15:2]
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata   // bit_value[0], alloc_id[14:1], full_res[15]
);

	logic [CMD_W-1:0] in_cmd;
	logic             out_bit;
	logic [ID_W-1:0]  out_id;
	logic             out_full;

	assign in_cmd   = s_axis_tdata[CMD_W-1:0];
	assign out_bit  = m_axis_tdata[0];
	assign out_id   = m_axis_tdata[ID_W:1];
	assign out_full = m_axis_tdata[ID_W+1];

	// A held result does not change until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted on consecutive cycles");

	// A full report carries no identifier and no query bit.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_full |-> out_id == '0 && !out_bit)
		else $error("full result with payload");

	// A query result carries no identifier.
	a_bit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_bit |-> out_id == '0)
		else $error("query result with identifier");

	// A query or free item cannot produce a new result on the next cycle.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (in_cmd == CMD_QUERY || in_cmd == CMD_FREE)
		|=> !$rose(m_axis_tvalid))
		else $error("result too early");

endmodule

bind two_level_bitmap_id_allocator_unit tlbia_chk u_tlbia_chk (.*);

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level bitmap ID allocator. A short table of
// opening items is followed by a random mix of queries, allocations, frees and
// no-ops, then scattered frees, six queries and a burst of refill allocations.
// Results are checked field by field against a bit-accurate allocator model.
// ----------------------------------------------------------------------------
module tb;
	import tlbia_pkg::*;

	localparam int WORD_BITS  = 64;
	localparam int NUM_DIRS   = 4;
	localparam int NUM_LEAVES = 256;
	localparam int RANDOM_ITEMS = 1570;

	typedef struct packed {
		logic        bit_value;
		logic [13:0] alloc_id;
		logic        full_res;
	} alloc_result_t;

	typedef struct packed {
		cmd_t          cmd;
		logic [13:0]   id;
		logic          typed;
		alloc_result_t res;
	} opening_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_valid = 1'b0;
	logic        s_ready;
	logic [15:0] s_data = '0;
	logic        m_valid;
	logic        m_ready = 1'b0;
	logic [15:0] m_data;

	// Model state of the allocator.
	logic [WORD_BITS-1:0] leaf_map [NUM_LEAVES];
	logic [WORD_BITS-1:0] dir_map [NUM_DIRS];
	int unsigned          cur_leaf;
	int unsigned          cur_dir;

	alloc_result_t pending_results [$];
	logic [13:0]   live_ids [$];
	int            error_count = 0;
	bit            calm = 1'b0;

	// Typed expectations only where they follow directly from reset state.
	opening_row_t opening_items [18] = '{
		'{CMD_QUERY, 14'd0,     1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_QUERY, 14'd16383, 1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_ALLOC, 14'd0,     1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_ALLOC, 14'd0,     1'b1, '{1'b0, 14'd1, 1'b0}},
		'{CMD_ALLOC, 14'd16383, 1'b1, '{1'b0, 14'd2, 1'b0}},
		'{CMD_QUERY, 14'd1,     1'b1, '{1'b1, 14'd0, 1'b0}},
		'{CMD_QUERY, 14'd3,     1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_FREE,  14'd0,     1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_QUERY, 14'd0,     1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_ALLOC, 14'd5,     1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_FREE,  14'd16383, 1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_FREE,  14'd16000, 1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_NOP,   14'd16383, 1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_NOP,   14'd0,     1'b1, '{1'b0, 14'd0, 1'b0}},
		'{CMD_QUERY, 14'd2,     1'b0, '{1'b0, 14'd0, 1'b0}},
		'{CMD_FREE,  14'd1,     1'b0, '{1'b0, 14'd0, 1'b0}},
		'{CMD_ALLOC, 14'd0,     1'b0, '{1'b0, 14'd0, 1'b0}},
		'{CMD_QUERY, 14'd64,    1'b0, '{1'b0, 14'd0, 1'b0}}
	};

	two_level_bitmap_id_allocator_unit #(
		.WORD_BITS (WORD_BITS),
		.NUM_DIRS  (NUM_DIRS),
		.NUM_LEAVES(NUM_LEAVES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata (s_data),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata (m_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
	end

	// Lowest non-full leaf listed by directory d.
	function automatic bit open_leaf_in_dir(int unsigned d, output int unsigned leaf);
		int unsigned l;
		leaf = 0;
		if (d >= NUM_DIRS)
			return 1'b0;
		for (int unsigned b = 0; b < WORD_BITS; b++) begin
			l = d * WORD_BITS + b;
			if (l >= NUM_LEAVES)
				return 1'b0;
			if (!dir_map[d][b]) begin
				leaf = l;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Current directory first, then every directory from the lowest.
	function automatic bit move_to_open_leaf();
		int unsigned l;
		if (open_leaf_in_dir(cur_dir, l)) begin
			cur_leaf = l;
			return 1'b1;
		end
		for (int unsigned d = 0; d < NUM_DIRS; d++) begin
			if (open_leaf_in_dir(d, l)) begin
				cur_dir = d;
				cur_leaf = l;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic alloc_result_t allocator_step(cmd_t cmd, logic [13:0] id);
		alloc_result_t r;
		int unsigned   leaf;
		int unsigned   pos;
		int unsigned   d;
		int unsigned   b;
		bit            ok;
		r = '0;
		leaf = id / WORD_BITS;
		pos = id % WORD_BITS;
		case (cmd)
			CMD_QUERY: begin
				if (leaf < NUM_LEAVES)
					r.bit_value = leaf_map[leaf][pos];
			end
			CMD_FREE: begin
				if (leaf < NUM_LEAVES) begin
					d = leaf / WORD_BITS;
					leaf_map[leaf][pos] = 1'b0;
					if (d < NUM_DIRS)
						dir_map[d][leaf % WORD_BITS] = 1'b0;
				end
			end
			CMD_ALLOC: begin
				ok = 1'b1;
				if (cur_leaf >= NUM_LEAVES || leaf_map[cur_leaf] == '1) begin
					if (!move_to_open_leaf() || leaf_map[cur_leaf] == '1)
						ok = 1'b0;
				end
				if (!ok) begin
					r.full_res = 1'b1;
				end else begin
					b = 0;
					for (int unsigned i = 0; i < WORD_BITS; i++) begin
						if (!leaf_map[cur_leaf][i]) begin
							b = i;
							break;
						end
					end
					leaf_map[cur_leaf][b] = 1'b1;
					r.alloc_id = 14'(cur_leaf * WORD_BITS + b);
					if (leaf_map[cur_leaf] == '1) begin
						if (cur_dir < NUM_DIRS)
							dir_map[cur_dir][cur_leaf % WORD_BITS] = 1'b1;
						void'(move_to_open_leaf());
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Drives one item, waits for its acceptance and files the expected result.
	task automatic issue_item(input cmd_t cmd, input logic [13:0] id, input logic typed,
		input alloc_result_t typed_res, output alloc_result_t predicted);
		bit taken;
		if (!calm && $urandom_range(99) < 30) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= {id, cmd};
		do begin
			@(negedge clk);
			taken = s_ready;
			@(posedge clk);
		end while (!taken);
		predicted = allocator_step(cmd, id);
		pending_results.push_back(typed ? typed_res : predicted);
		if (cmd == CMD_ALLOC && !predicted.full_res)
			live_ids.push_back(predicted.alloc_id);
	endtask

	function automatic logic [13:0] take_live_id();
		int unsigned idx;
		logic [13:0] id;
		if (live_ids.size() == 0)
			return 14'($urandom());
		idx = $urandom_range(0, live_ids.size() - 1);
		id = live_ids[idx];
		live_ids.delete(idx);
		return id;
	endfunction

	function automatic logic [13:0] peek_id();
		if (live_ids.size() == 0 || $urandom_range(1))
			return 14'($urandom());
		return live_ids[$urandom_range(0, live_ids.size() - 1)];
	endfunction

	// An item is taken at the next rising edge when both lines are high here.
	always @(negedge clk) begin : result_check
		alloc_result_t want;
		alloc_result_t got;
		if (arst_n && m_valid && m_ready) begin
			got.bit_value = m_data[0];
			got.alloc_id = m_data[14:1];
			got.full_res = m_data[15];
			if (pending_results.size() == 0) begin
				$error("unexpected result item: tdata %h", m_data);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.bit_value !== want.bit_value) begin
					$error("bit_value mismatch: expected %0d, actual %0d",
						want.bit_value, got.bit_value);
					error_count++;
				end
				if (got.alloc_id !== want.alloc_id) begin
					$error("alloc_id mismatch: expected %0d, actual %0d",
						want.alloc_id, got.alloc_id);
					error_count++;
				end
				if (got.full_res !== want.full_res) begin
					$error("full_res mismatch: expected %0d, actual %0d",
						want.full_res, got.full_res);
					error_count++;
				end
			end
		end
	end

	initial begin
		alloc_result_t res;
		cmd_t          cmd;
		logic [13:0]   id;
		int unsigned   pick;

		foreach (leaf_map[i])
			leaf_map[i] = '0;
		foreach (dir_map[i])
			dir_map[i] = '0;
		cur_leaf = 0;
		cur_dir = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening_items[i])
			issue_item(opening_items[i].cmd, opening_items[i].id, opening_items[i].typed,
				opening_items[i].res, res);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 600 && n < 900);
			pick = $urandom_range(99);
			if (pick < 50) begin
				cmd = CMD_ALLOC;
				id = 14'($urandom());
			end else if (pick < 68) begin
				cmd = CMD_FREE;
				id = ($urandom_range(4) != 0) ? take_live_id() : 14'($urandom());
			end else if (pick < 93) begin
				cmd = CMD_QUERY;
				id = peek_id();
			end else begin
				cmd = CMD_NOP;
				id = 14'($urandom());
			end
			issue_item(cmd, id, 1'b0, '0, res);
		end
		calm = 1'b0;

		// Scattered frees leave holes in earlier leaves that later searches must find.
		repeat (24)
			issue_item(CMD_FREE, take_live_id(), 1'b0, '0, res);
		repeat (6)
			issue_item(CMD_QUERY, peek_id(), 1'b0, '0, res);
		repeat (30)
			issue_item(CMD_ALLOC, 14'($urandom()), 1'b0, '0, res);
		s_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
